/* design/dscs_pkg.sv */
// ----------------------------------------------------------------------------
// dscs_pkg
// Shared types and constants for the dual stick calibrate and scale block.
// ----------------------------------------------------------------------------
package dscs_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int CMD_BITS    = 12;
  localparam int SCALE_BITS  = 11;
  localparam int PROD_BITS   = SAMPLE_BITS + SCALE_BITS;
  localparam int QDEPTH      = 2;

  localparam logic [SAMPLE_BITS-1:0] SMASK        = '1;
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [COUNT_BITS-1:0]  CMAX         = '1;

  localparam logic [2:0] REG_DEADZONE = 3'd0;
  localparam logic [2:0] REG_NORMAL   = 3'd1;
  localparam logic [2:0] REG_BOOST    = 3'd2;
  localparam logic [2:0] REG_RANGE    = 3'd3;
  localparam logic [2:0] REG_STILL    = 3'd4;
  localparam logic [2:0] REG_HOLD     = 3'd5;

  localparam logic [1:0] PH_RANGE   = 2'd0;
  localparam logic [1:0] PH_CENTER  = 2'd1;
  localparam logic [1:0] PH_CONTROL = 2'd2;

  typedef struct packed {
    logic [10:0] deadzone;
    logic [10:0] normal_scale;
    logic [10:0] boost_scale;
    logic [11:0] range_threshold;
    logic [11:0] still_span_limit;
    logic [15:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_adc;
    logic [SAMPLE_BITS-1:0] right_adc;
    logic                   left_turbo;
    logic                   right_turbo;
    logic                   recalibrate;
    logic [31:0]            now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             phase;
    logic                   condition_met;
    logic [CMD_BITS-1:0]    left_drive;
    logic [CMD_BITS-1:0]    right_drive;
    logic [SAMPLE_BITS-1:0] left_low;
    logic [SAMPLE_BITS-1:0] left_high;
    logic [SAMPLE_BITS-1:0] right_low;
    logic [SAMPLE_BITS-1:0] right_high;
    logic [SAMPLE_BITS-1:0] left_still_span;
    logic [SAMPLE_BITS-1:0] right_still_span;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPDATE, ST_CENTER, ST_SCALE, ST_OUT
  } back_state_t;

endpackage

/* design/dscs_if.sv */
// ----------------------------------------------------------------------------
// dscs_in_if / dscs_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface dscs_in_if import dscs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dscs_out_if import dscs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/dscs_divider.sv */
// ----------------------------------------------------------------------------
// dscs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dscs_divider import dscs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_BITS-1:0] dividend,
  input  logic [SUM_BITS-1:0] divisor,
  output logic                busy,
  output logic [SUM_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_BITS:0]   trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[SUM_BITS-1]};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(SUM_BITS);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = SUM_BITS'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SUM_BITS-1:0];
        quo_nxt = {quo_r[SUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

/* design/dscs_front.sv */
// ----------------------------------------------------------------------------
// dscs_front
// Accepts samples and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dscs_front import dscs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  dscs_in_if.sink         in_ch,
  output logic            q_valid,
  output in_item_t        q_data,
  input  logic            q_pop
);

  in_item_t  mem [QDEPTH];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push;

  assign in_ch.ready = (cnt_r != 2'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_data      = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem[wp_r] <= in_ch.data;
  end

endmodule

/* design/dscs_back.sv */
// ----------------------------------------------------------------------------
// dscs_back
// Calibration state, phase sequencing and command scaling.
// ----------------------------------------------------------------------------
module dscs_back import dscs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  in_item_t q_data,
  output logic     q_pop,
  dscs_out_if.source out_ch
);

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  back_state_t st_r, st_nxt;
  in_item_t    it_r;
  logic [1:0]  phase_r, phase_nxt, ph_out_r;
  smp_t        rmin_r [2], rmax_r [2], ctr_r [2], smin_r [2], smax_r [2];
  smp_t        rmin_n [2], rmax_n [2], ctr_n [2], smin_n [2], smax_n [2];
  logic [SUM_BITS-1:0] ssum_r [2], ssum_n [2];
  logic [COUNT_BITS-1:0] scnt_r, scnt_n;
  logic        rarm_r, rarm_n, sarm_r, sarm_n, cond_r, cond_n;
  logic [31:0] rsince_r, rsince_n, ssince_r, ssince_n;
  logic        side_r;           // which stick the shared divider serves
  logic        div_go_r;
  logic [CMD_BITS-1:0] cmd_r [2];
  logic        hold_cmd_r [2];    // command forced to zero, quotient ignored
  logic        neg_r [2];
  logic [10:0] scl_r [2];
  out_item_t   out_r;
  logic        ovalid_r;

  logic                div_start, div_busy;
  logic [SUM_BITS-1:0] div_a, div_b, div_q;

  dscs_divider u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  function automatic smp_t span_of(smp_t mx, smp_t mn, logic [COUNT_BITS-1:0] c);
    return (c == '0 || mx < mn) ? '0 : smp_t'(mx - mn);
  endfunction

  smp_t raw [2];
  assign raw[0] = it_r.left_adc;
  assign raw[1] = it_r.right_adc;

  // per-sample state update, done in ST_UPDATE
  logic rok [2];
  logic go_center;
  always_comb begin
    phase_nxt = phase_r;
    rmin_n = rmin_r; rmax_n = rmax_r; ctr_n = ctr_r;
    smin_n = smin_r; smax_n = smax_r; ssum_n = ssum_r; scnt_n = scnt_r;
    rarm_n = rarm_r; sarm_n = sarm_r; rsince_n = rsince_r; ssince_n = ssince_r;
    cond_n = 1'b0;
    go_center = 1'b0;
    rok[0] = 1'b0; rok[1] = 1'b0;
    if (it_r.recalibrate) begin
      phase_nxt = PH_RANGE; rarm_n = 1'b0; sarm_n = 1'b0;
      rsince_n = '0; ssince_n = '0; scnt_n = '0;
      for (int i = 0; i < 2; i++) begin
        rmin_n[i] = SMASK; rmax_n[i] = '0; ctr_n[i] = CENTER_RESET;
        smin_n[i] = SMASK; smax_n[i] = '0; ssum_n[i] = '0;
      end
    end
    if (phase_nxt == PH_RANGE) begin
      for (int i = 0; i < 2; i++) begin
        if (raw[i] < rmin_n[i]) rmin_n[i] = raw[i];
        if (raw[i] > rmax_n[i]) rmax_n[i] = raw[i];
        rok[i] = (rmax_n[i] > rmin_n[i]) &&
                 (smp_t'(rmax_n[i] - rmin_n[i]) >= cfg.range_threshold);
      end
      cond_n = rok[0] && rok[1];
      if (cond_n) begin
        if (!rarm_n) begin
          rarm_n = 1'b1; rsince_n = it_r.now_ms;
        end else if ((it_r.now_ms - rsince_n) >= {16'd0, cfg.hold_ms}) begin
          phase_nxt = PH_CENTER; rarm_n = 1'b0; sarm_n = 1'b0; scnt_n = '0;
          for (int i = 0; i < 2; i++) begin
            smin_n[i] = SMASK; smax_n[i] = '0; ssum_n[i] = '0;
          end
        end
      end else begin
        rarm_n = 1'b0;
      end
    end else if (phase_nxt == PH_CENTER) begin
      if (scnt_n == '0) begin
        scnt_n = COUNT_BITS'(1);
        for (int i = 0; i < 2; i++) begin
          smin_n[i] = raw[i]; smax_n[i] = raw[i]; ssum_n[i] = SUM_BITS'(raw[i]);
        end
      end else begin
        for (int i = 0; i < 2; i++) begin
          if (raw[i] < smin_n[i]) smin_n[i] = raw[i];
          if (raw[i] > smax_n[i]) smax_n[i] = raw[i];
        end
        if (scnt_n < CMAX) begin
          for (int i = 0; i < 2; i++) ssum_n[i] = ssum_n[i] + SUM_BITS'(raw[i]);
          scnt_n = scnt_n + 1'b1;
        end
      end
      cond_n = (span_of(smax_n[0], smin_n[0], scnt_n) < cfg.still_span_limit) &&
               (span_of(smax_n[1], smin_n[1], scnt_n) < cfg.still_span_limit);
      if (cond_n) begin
        if (!sarm_n) begin
          sarm_n = 1'b1; ssince_n = it_r.now_ms;
        end else if ((it_r.now_ms - ssince_n) >= {16'd0, cfg.hold_ms}) begin
          go_center = 1'b1; sarm_n = 1'b0;
        end
      end else begin
        sarm_n = 1'b0; scnt_n = COUNT_BITS'(1);
        for (int i = 0; i < 2; i++) begin
          smin_n[i] = raw[i]; smax_n[i] = raw[i]; ssum_n[i] = SUM_BITS'(raw[i]);
        end
      end
    end
  end

  // scaling setup: numerator and divisor for one side
  logic [SAMPLE_BITS:0] s_d, s_n;
  logic                 s_neg, s_zero;
  logic [10:0]          s_scl;
  smp_t                 s_raw, s_ctr;
  always_comb begin
    s_raw = raw[side_r];
    s_ctr = ctr_r[side_r];
    s_scl = (side_r ? it_r.right_turbo : it_r.left_turbo) ? cfg.boost_scale
                                                          : cfg.normal_scale;
    if (s_raw >= s_ctr) begin
      s_neg = 1'b1;
      s_n   = {1'b0, smp_t'(s_raw - s_ctr)};
      s_d   = {1'b0, rmax_r[side_r]} - {1'b0, s_ctr};
    end else begin
      s_neg = 1'b0;
      s_n   = {1'b0, smp_t'(s_ctr - s_raw)};
      s_d   = {1'b0, s_ctr} - {1'b0, rmin_r[side_r]};
    end
    s_zero = s_d[SAMPLE_BITS] || (s_d == '0);
  end

  logic [PROD_BITS-1:0] prod_r;
  logic [SUM_BITS-1:0]  dvs_r;

  always_comb begin
    div_start = div_go_r;
    if (st_r == ST_CENTER) begin
      div_a = ssum_r[side_r];
      div_b = SUM_BITS'(scnt_r);
    end else begin
      div_a = SUM_BITS'(prod_r);
      div_b = dvs_r;
    end
  end

  // clamp, deadzone and sign of one command
  function automatic logic [CMD_BITS-1:0] finish_cmd(logic [SUM_BITS-1:0] q,
      logic [10:0] scl, logic neg, logic [10:0] dz);
    logic [10:0] m;
    m = (q > SUM_BITS'(scl)) ? scl : q[10:0];
    if (m < dz) m = '0;
    return neg ? CMD_BITS'(-$signed({1'b0, m})) : CMD_BITS'({1'b0, m});
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (q_valid) st_nxt = ST_UPDATE;
      ST_UPDATE: st_nxt = go_center ? ST_CENTER :
                          (phase_nxt == PH_RANGE || phase_nxt == PH_CENTER) ? ST_OUT
                                                                            : ST_SCALE;
      ST_CENTER: if (!div_go_r && !div_busy && side_r) st_nxt = ST_OUT;
      ST_SCALE:  if (!div_go_r && !div_busy && side_r && dvs_r != '0) st_nxt = ST_OUT;
      ST_OUT:    if (!ovalid_r || out_ch.ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  assign q_pop        = (st_r == ST_IDLE) && q_valid;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; phase_r <= PH_RANGE; ovalid_r <= 1'b0; div_go_r <= 1'b0;
      rarm_r <= 1'b0; sarm_r <= 1'b0; rsince_r <= '0; ssince_r <= '0; scnt_r <= '0;
      side_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        rmin_r[i] <= SMASK; rmax_r[i] <= '0; ctr_r[i] <= CENTER_RESET;
        smin_r[i] <= SMASK; smax_r[i] <= '0; ssum_r[i] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      // divider kick: center pass per side, or after loading scale operands
      div_go_r <= (st_r == ST_UPDATE && go_center) ||
                  (st_r == ST_CENTER && !div_go_r && !div_busy && !side_r) ||
                  (st_r == ST_SCALE && !div_go_r && !div_busy && dvs_r == '0);
      if (st_r == ST_OUT && (!ovalid_r || out_ch.ready)) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (q_valid) it_r <= q_data;
        ST_UPDATE: begin
          ph_out_r <= it_r.recalibrate ? PH_RANGE : phase_r;
          phase_r <= phase_nxt; rmin_r <= rmin_n; rmax_r <= rmax_n; ctr_r <= ctr_n;
          smin_r <= smin_n; smax_r <= smax_n; ssum_r <= ssum_n; scnt_r <= scnt_n;
          rarm_r <= rarm_n; sarm_r <= sarm_n; rsince_r <= rsince_n;
          ssince_r <= ssince_n; cond_r <= cond_n; side_r <= 1'b0;
          cmd_r[0] <= '0; cmd_r[1] <= '0;
        end
        ST_CENTER: if (!div_go_r && !div_busy) begin
          ctr_r[side_r] <= div_q[SAMPLE_BITS-1:0];
          if (!side_r) begin
            side_r <= 1'b1;
          end else begin
            phase_r <= PH_CONTROL;
          end
        end
        ST_SCALE: if (!div_go_r && !div_busy) begin
          // first pass through this state only loads operands
          if (dvs_r == '0) begin
            hold_cmd_r[side_r] <= s_zero || s_scl == '0;
            neg_r[side_r] <= s_neg; scl_r[side_r] <= s_scl;
            prod_r <= PROD_BITS'(s_n[SAMPLE_BITS-1:0] * s_scl);
            dvs_r  <= s_zero ? SUM_BITS'(1) : SUM_BITS'(s_d);
          end else begin
            cmd_r[side_r] <= hold_cmd_r[side_r] ? '0 :
                finish_cmd(div_q, scl_r[side_r], neg_r[side_r], cfg.deadzone);
            dvs_r <= '0;
            side_r <= 1'b1;
          end
        end
        ST_OUT: if (!ovalid_r || out_ch.ready) begin
          out_r.phase <= ph_out_r;
          out_r.condition_met <= cond_r;
          out_r.left_drive <= cmd_r[0];
          out_r.right_drive <= cmd_r[1];
          out_r.left_low <= rmin_r[0];
          out_r.left_high <= rmax_r[0];
          out_r.right_low <= rmin_r[1];
          out_r.right_high <= rmax_r[1];
          out_r.left_still_span <= span_of(smax_r[0], smin_r[0], scnt_r);
          out_r.right_still_span <= span_of(smax_r[1], smin_r[1], scnt_r);
        end
        default: ;
      endcase
    end
    if (st_r == ST_IDLE) dvs_r <= '0;
  end

endmodule

/* design/dual_stick_calibrate_and_scale.sv */
// ----------------------------------------------------------------------------
// dual_stick_calibrate_and_scale
// Two-stick range/center calibration followed by deadzoned command scaling.
// ----------------------------------------------------------------------------
// A two-entry queue takes samples while the back end works on an earlier one.
// A sample in the range or zero-center phase passes through the idle, update
// and output states of the back end. The step that sets the centers and a
// control sample each run the shared 28-step shift-subtract divider once per
// stick, with a start and a finish step around every pass (plus an operand
// load per stick when scaling). The divider is what sets the rate; a result
// held by the receiver stalls the back end in ST_OUT. One result beat per sample.
module dual_stick_calibrate_and_scale import dscs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dscs_in_if.sink     in_ch,
  dscs_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t     cfg_r;
  logic     q_valid, q_pop;
  in_item_t q_data;
  logic     wr;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{deadzone: 11'd40, normal_scale: 11'd1000, boost_scale: 11'd2000,
                 range_threshold: 12'd3072, still_span_limit: 12'd30, hold_ms: 16'd500};
    end else if (wr) begin
      unique case (idx)
        REG_DEADZONE: cfg_r.deadzone         <= cfg_pwdata[10:0];
        REG_NORMAL:   cfg_r.normal_scale     <= cfg_pwdata[10:0];
        REG_BOOST:    cfg_r.boost_scale      <= cfg_pwdata[10:0];
        REG_RANGE:    cfg_r.range_threshold  <= cfg_pwdata[11:0];
        REG_STILL:    cfg_r.still_span_limit <= cfg_pwdata[11:0];
        REG_HOLD:     cfg_r.hold_ms          <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEADZONE: cfg_prdata = {21'd0, cfg_r.deadzone};
      REG_NORMAL:   cfg_prdata = {21'd0, cfg_r.normal_scale};
      REG_BOOST:    cfg_prdata = {21'd0, cfg_r.boost_scale};
      REG_RANGE:    cfg_prdata = {20'd0, cfg_r.range_threshold};
      REG_STILL:    cfg_prdata = {20'd0, cfg_r.still_span_limit};
      REG_HOLD:     cfg_prdata = {16'd0, cfg_r.hold_ms};
      default:      cfg_prdata = '0;
    endcase
  end

  dscs_front u_front (.clk, .rst_n, .in_ch, .q_valid, .q_data, .q_pop);
  dscs_back  u_back  (.clk, .rst_n, .cfg(cfg_r), .q_valid, .q_data, .q_pop, .out_ch);

  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.phase != PH_CONTROL |->
      out_ch.data.left_drive == '0 && out_ch.data.right_drive == '0)
    else $error("command outside control phase");
  a_cond_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.phase == PH_CONTROL |-> !out_ch.data.condition_met)
    else $error("condition flagged in control phase");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped while stalled");

endmodule
